// ----- rtl/gnc_pkg.sv -----
// ----------------------------------------------------------------------------
// gnc_pkg: shared types and constants for the gradient norm clipper
// Controller states, command and status bundles, fixed-point constants.
// ----------------------------------------------------------------------------
package gnc_pkg;

  // fixed-point widths
  localparam int unsigned GradW  = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned ScaleW = 17;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned ProdW  = GradW + ScaleW + 1;

  // scale of one in Q1.16
  localparam logic [ScaleW-1:0] ScaleOne = 17'h10000;

  // iteration counts of the shared root and divide steps
  localparam int unsigned RootSteps = SumW / 2;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned CntW      = $clog2(RootSteps);
  localparam logic [CntW-1:0] RootLast = CntW'(RootSteps - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(DivSteps - 1);

  // input mode and result kind codes
  localparam logic ModeAccum   = 1'b0;
  localparam logic ModeApply   = 1'b1;
  localparam logic KindElement = 1'b0;
  localparam logic KindReport  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROOT,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic add;
    logic root_start;
    logic root_step;
    logic cmp;
    logic div_step;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode_apply;
    logic last;
    logic root_done;
    logic div_done;
    logic clip_need;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/gnc_dp.sv -----
// ----------------------------------------------------------------------------
// gnc_dp: datapath of the gradient norm clipper
// Squares and sums elements, runs the bit-serial root and divide, scales
// elements and holds the result register.
// ----------------------------------------------------------------------------
module gnc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gnc_pkg::cmd_t                       cmd_i,
  output gnc_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic        [31:0]                  cfg_wdata_i,
  input  logic                                mode_i,
  input  logic signed [gnc_pkg::GradW-1:0]    grad_value_i,
  input  logic                                last_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                kind_o,
  output logic signed [gnc_pkg::GradW-1:0]    scaled_grad_o,
  output logic        [31:0]                  norm_o,
  output logic        [gnc_pkg::ScaleW-1:0]   scale_o,
  output logic                                clipped_o,
  output logic                                sum_saturated_o
);

  // input capture
  logic                              mode_q, last_q;
  logic signed [gnc_pkg::GradW-1:0]  grad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      last_q <= last_i;
      grad_q <= grad_value_i;
    end
  end

  // configuration register
  logic [31:0] clip_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_limit_q <= '0;
    end else if (cfg_we_i) begin
      clip_limit_q <= cfg_wdata_i;
    end
  end

  // stored scale
  logic [gnc_pkg::ScaleW-1:0] cur_scale_q;

  // square and scale products, registered
  logic [31:0]                       mag;
  logic [gnc_pkg::SumW-1:0]          sq_c, sq_q;
  logic signed [gnc_pkg::ScaleW:0]   scale_s;
  logic signed [gnc_pkg::ProdW-1:0]  prod_c, prod_q;

  assign mag     = grad_q[31] ? 32'(-grad_q) : 32'(grad_q);
  assign sq_c    = {32'd0, mag} * {32'd0, mag};
  assign scale_s = signed'({1'b0, cur_scale_q});
  assign prod_c  = gnc_pkg::ProdW'(grad_q) * gnc_pkg::ProdW'(scale_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sq_q   <= sq_c;
      prod_q <= prod_c;
    end
  end

  // saturating sum of squares
  logic [gnc_pkg::SumW-1:0] sum_q;
  logic                     ovf_q;
  logic [gnc_pkg::SumW:0]   sum_ext;

  assign sum_ext = {1'b0, sum_q} + {1'b0, sq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.add) begin
      if (sum_ext[gnc_pkg::SumW]) begin
        sum_q <= '1;
        ovf_q <= 1'b1;
      end else begin
        sum_q <= sum_ext[gnc_pkg::SumW-1:0];
      end
    end else if (cmd_i.emit && (mode_q == gnc_pkg::ModeAccum)) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end
  end

  // shared step counter
  logic [gnc_pkg::CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start || cmd_i.cmp) begin
      cnt_q <= '0;
    end else if (cmd_i.root_step || cmd_i.div_step) begin
      cnt_q <= cnt_q + gnc_pkg::CntW'(1);
    end
  end

  // digit-by-digit square root, one root bit per step
  logic [31:0] root_q;
  logic [33:0] rrem_q;
  logic [5:0]  pair_idx;
  logic [35:0] rrem_sh, rtrial;
  logic        rbit;

  assign pair_idx = {~cnt_q, 1'b0};
  assign rrem_sh  = {rrem_q, sum_q[pair_idx +: 2]};
  assign rtrial   = {2'b00, root_q, 2'b01};
  assign rbit     = (rrem_sh >= rtrial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      root_q <= '0;
      rrem_q <= '0;
    end else if (cmd_i.root_step) begin
      root_q <= {root_q[30:0], rbit};
      rrem_q <= rbit ? 34'(rrem_sh - rtrial) : 34'(rrem_sh);
    end
  end

  // restoring divide of the clip limit * 2^16 by the norm
  logic [31:0]              drem_q;
  logic [32:0]              drem_sh;
  logic                     dbit;
  logic [gnc_pkg::QuoW-1:0] quo_q;
  logic                     clip_q;
  logic                     clip_need;

  assign clip_need = (clip_limit_q != '0) && (root_q > clip_limit_q);
  assign drem_sh   = {drem_q, 1'b0};
  assign dbit      = (drem_sh >= {1'b0, root_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      drem_q <= clip_limit_q;
      quo_q  <= '0;
      clip_q <= clip_need;
    end else if (cmd_i.div_step) begin
      drem_q <= dbit ? 32'(drem_sh - {1'b0, root_q}) : drem_sh[31:0];
      quo_q  <= {quo_q[gnc_pkg::QuoW-2:0], dbit};
    end
  end

  // scale chosen by the pass
  logic [gnc_pkg::ScaleW-1:0] new_scale;

  assign new_scale = clip_q ? {1'b0, quo_q} : gnc_pkg::ScaleOne;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_scale_q <= gnc_pkg::ScaleOne;
    end else if (cmd_i.emit && (mode_q == gnc_pkg::ModeAccum)) begin
      cur_scale_q <= new_scale;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (mode_q == gnc_pkg::ModeApply) begin
        kind_o          <= gnc_pkg::KindElement;
        scaled_grad_o   <= prod_q[gnc_pkg::GradW+15:16];
        norm_o          <= '0;
        scale_o         <= cur_scale_q;
        clipped_o       <= (cur_scale_q < gnc_pkg::ScaleOne);
        sum_saturated_o <= 1'b0;
      end else begin
        kind_o          <= gnc_pkg::KindReport;
        scaled_grad_o   <= '0;
        norm_o          <= root_q;
        scale_o         <= new_scale;
        clipped_o       <= clip_q;
        sum_saturated_o <= ovf_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // status back to the controller
  assign status_o.mode_apply = (mode_q == gnc_pkg::ModeApply);
  assign status_o.last       = last_q;
  assign status_o.root_done  = (cnt_q == gnc_pkg::RootLast);
  assign status_o.div_done   = (cnt_q == gnc_pkg::DivLast);
  assign status_o.clip_need  = clip_need;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ----- rtl/gnc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gnc_ctrl: controller of the gradient norm clipper
// Sequences capture, multiply, accumulate, root, divide and result load.
// ----------------------------------------------------------------------------
module gnc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gnc_pkg::status_t  status_i,
  output gnc_pkg::cmd_t     cmd_o
);

  gnc_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gnc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gnc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gnc_pkg::ST_MUL;
      end
      gnc_pkg::ST_MUL: begin
        state_d = status_i.mode_apply ? gnc_pkg::ST_OUT : gnc_pkg::ST_ADD;
      end
      gnc_pkg::ST_ADD: begin
        state_d = status_i.last ? gnc_pkg::ST_ROOT : gnc_pkg::ST_IDLE;
      end
      gnc_pkg::ST_ROOT: begin
        if (status_i.root_done) state_d = gnc_pkg::ST_CMP;
      end
      gnc_pkg::ST_CMP: begin
        state_d = status_i.clip_need ? gnc_pkg::ST_DIV : gnc_pkg::ST_OUT;
      end
      gnc_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = gnc_pkg::ST_OUT;
      end
      gnc_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = gnc_pkg::ST_IDLE;
      end
      default: state_d = gnc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      gnc_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      gnc_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      gnc_pkg::ST_ADD: begin
        cmd_o.add        = 1'b1;
        cmd_o.root_start = status_i.last;
      end
      gnc_pkg::ST_ROOT: cmd_o.root_step = 1'b1;
      gnc_pkg::ST_CMP:  cmd_o.cmp       = 1'b1;
      gnc_pkg::ST_DIV:  cmd_o.div_step  = 1'b1;
      gnc_pkg::ST_OUT:  cmd_o.emit      = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/grad_norm_clipper.sv -----
// ----------------------------------------------------------------------------
// grad_norm_clipper: two-pass gradient norm clipping on a Q16.16 stream
// Accumulate and apply elements pass capture, multiply, and add or result
// load; a last element adds the 32-step bit-serial root and, when clipping,
// the 16-step divide, with root and divide sharing one counter.
// Reset (async, active low) clears the sum, sets the scale to one, clip limit 0.
// ----------------------------------------------------------------------------
module grad_norm_clipper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic        [31:0]                cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic signed [gnc_pkg::GradW-1:0]  grad_value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic signed [gnc_pkg::GradW-1:0]  scaled_grad_o,
  output logic        [31:0]                norm_o,
  output logic        [gnc_pkg::ScaleW-1:0] scale_o,
  output logic                              clipped_o,
  output logic                              sum_saturated_o
);

  gnc_pkg::cmd_t    cmd;
  gnc_pkg::status_t status;

  // controller
  gnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  gnc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (mode_i),
    .grad_value_i    (grad_value_i),
    .last_i          (last_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .scaled_grad_o   (scaled_grad_o),
    .norm_o          (norm_o),
    .scale_o         (scale_o),
    .clipped_o       (clipped_o),
    .sum_saturated_o (sum_saturated_o)
  );

  // one beat at a time: an accepted beat stalls the input next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // a clipped report carries a scale below one, an unclipped one exactly one
  a_report_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == gnc_pkg::KindReport)) |->
      (clipped_o ? (scale_o < gnc_pkg::ScaleOne) : (scale_o == gnc_pkg::ScaleOne)))
    else $error("report scale disagrees with clipped flag");

  // element beats carry no norm and no saturation flag
  a_element_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == gnc_pkg::KindElement)) |->
      ((norm_o == '0) && !sum_saturated_o))
    else $error("element beat carries report fields");

endmodule
